@@ rtl/core/pdd_pkg.sv @@
// ----------------------------------------------------------------------------
// pdd_pkg
// Shared constants and types for the packet delay / drop impairment unit.
// ----------------------------------------------------------------------------
package pdd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTION_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_PROTOCOL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_PORT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERCENT_APPLIED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY_MS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY_MS    = 3'd5;

  // action codes
  localparam logic [15:0] MODE_JITTER  = 16'd1;
  localparam logic [15:0] MODE_DROP    = 16'd2;
  localparam logic [15:0] MODE_REORDER = 16'd3;

  localparam logic [7:0]  PROTO_TCP      = 8'h06;
  localparam logic [7:0]  PROTO_UDP      = 8'h11;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

  localparam logic [15:0] IP_HDR_END  = 16'd34;
  localparam logic [15:0] TCP_HDR_END = 16'd54;
  localparam logic [15:0] UDP_HDR_END = 16'd42;

  localparam int          NS_PER_MS_W = 20;
  localparam logic [NS_PER_MS_W-1:0] NS_PER_MS = 20'd1000000;
  localparam logic [15:0] PERCENT_MOD = 16'd100;

  // serial remainder unit
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic [15:0] action_mode;
    logic [15:0] match_protocol;
    logic [15:0] match_port;
    logic [15:0] percent_applied;
    logic [15:0] min_delay_ms;
    logic [15:0] max_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] rem;
  } rem_rsp_t;

endpackage

@@ rtl/core/pdd_in_if.sv @@
// ----------------------------------------------------------------------------
// pdd_in_if
// Descriptor channel into the impairment unit: valid / ready and payload.
// ----------------------------------------------------------------------------
interface pdd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] meta_ethertype;
  logic [15:0] frame_length;
  logic [15:0] frame_ethertype;
  logic [7:0]  ip_proto_byte;
  logic [15:0] dest_port_field;
  logic [63:0] now_ns;
  logic [31:0] percent_draw;
  logic [31:0] delay_draw;

  modport source (
    output valid, meta_ethertype, frame_length, frame_ethertype, ip_proto_byte,
           dest_port_field, now_ns, percent_draw, delay_draw,
    input  ready
  );
  modport sink (
    input  valid, meta_ethertype, frame_length, frame_ethertype, ip_proto_byte,
           dest_port_field, now_ns, percent_draw, delay_draw,
    output ready
  );
endinterface

@@ rtl/core/pdd_out_if.sv @@
// ----------------------------------------------------------------------------
// pdd_out_if
// Verdict channel out of the impairment unit: valid / ready and payload.
// ----------------------------------------------------------------------------
interface pdd_out_if;
  logic        valid;
  logic        ready;
  logic        drop_packet;
  logic        time_written;
  logic [63:0] departure_ns;

  modport source (
    output valid, drop_packet, time_written, departure_ns,
    input  ready
  );
  modport sink (
    input  valid, drop_packet, time_written, departure_ns,
    output ready
  );
endinterface

@@ rtl/core/packet_delay_drop_impairment_unit.sv @@
// ----------------------------------------------------------------------------
// packet_delay_drop_impairment_unit
// Per-packet filter, percentage gate and drop / jitter / fixed-delay action.
// ----------------------------------------------------------------------------
// One descriptor is handled at a time and gives exactly one verdict beat.
// A descriptor that does not match the filter goes straight to the done
// state; a matching one runs the percentage draw through the shared serial
// remainder unit, then goes to the done state for drop, pass or a gate miss,
// or through a multiply step and a 64-bit add step for fixed delay. A jitter
// packet uses that unit a second time for the delay draw before those steps.
// The input is ready again in the cycle the verdict is offered; the serial
// remainder unit is what sets the spacing of matching descriptors. A
// finished verdict sits in an output register, so the sink may stall without
// losing it; the next descriptor is accepted as soon as the sequencer is
// back in idle.
// ----------------------------------------------------------------------------
module packet_delay_drop_impairment_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  pdd_in_if.sink                          in_ch,
  pdd_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [pdd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [pdd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pdd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PCT  = 6'b000010,
    S_DLY  = 6'b000100,
    S_MUL  = 6'b001000,
    S_ADD  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  cfg_t     cfg;
  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  state_t      state_r;
  logic [63:0] last_r;
  logic [63:0] now_r;
  logic [31:0] ddraw_r;
  logic        drop_r;
  logic        written_r;
  logic [63:0] dep_r;
  logic [15:0] dms_r;
  logic [31:0] dns_r;

  logic        out_valid_r;
  logic        out_drop_r;
  logic        out_written_r;
  logic [63:0] out_dep_r;

  logic        accept;
  logic        match_w;
  logic        proto_ok;
  logic        gate;
  logic        is_jitter;
  logic [15:0] r16_dms;
  logic [31:0] prod;
  logic [63:0] add_base;
  logic        out_free;

  pdd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pdd_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign is_jitter = (cfg.action_mode == MODE_JITTER);

  // protocol / port filter on the incoming descriptor
  always_comb begin
    proto_ok = (in_ch.ip_proto_byte == cfg.match_protocol[7:0]) &&
               (((in_ch.ip_proto_byte == PROTO_TCP) &&
                 (in_ch.frame_length >= TCP_HDR_END)) ||
                ((in_ch.ip_proto_byte == PROTO_UDP) &&
                 (in_ch.frame_length >= UDP_HDR_END))) &&
               (in_ch.dest_port_field == cfg.match_port);
    if (cfg.percent_applied == 16'd0) begin
      match_w = 1'b0;
    end else if (cfg.match_protocol == ETHERTYPE_IPV4) begin
      match_w = (in_ch.meta_ethertype == ETHERTYPE_IPV4);
    end else begin
      match_w = (in_ch.frame_length >= IP_HDR_END) &&
                (in_ch.frame_ethertype == ETHERTYPE_IPV4) && proto_ok;
    end
  end

  // remainder unit requests: percent draw on a matching accept, delay draw for jitter
  always_comb begin
    gate = (rem_rsp.rem < cfg.percent_applied);
    rem_req.start    = 1'b0;
    rem_req.dividend = ddraw_r;
    rem_req.divisor  = cfg.max_delay_ms;
    case (state_r)
      S_IDLE: begin
        rem_req.start    = accept && match_w;
        rem_req.dividend = in_ch.percent_draw;
        rem_req.divisor  = PERCENT_MOD;
      end
      S_PCT: begin
        rem_req.start = rem_rsp.done && gate && is_jitter;
      end
      default: rem_req.start = 1'b0;
    endcase
  end

  assign r16_dms  = (rem_rsp.rem < cfg.min_delay_ms) ? cfg.min_delay_ms : rem_rsp.rem;
  // product wraps at 32 bits
  assign prod     = {16'd0, dms_r} * {12'd0, NS_PER_MS};
  assign add_base = (is_jitter && (now_r < last_r)) ? last_r : now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            // follow-on spacing happens before the gate
            if (match_w && (last_r != 64'd0)) begin
              last_r <= last_r + 64'(NS_PER_MS);
            end
            state_r <= match_w ? S_PCT : S_DONE;
          end
        end
        S_PCT: begin
          if (rem_rsp.done) begin
            if (!gate) begin
              state_r <= S_DONE;
            end else if (is_jitter) begin
              state_r <= S_DLY;
            end else if (cfg.action_mode == MODE_REORDER) begin
              state_r <= S_MUL;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_DLY: begin
          if (rem_rsp.done) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_ADD;
        end
        S_ADD: begin
          last_r  <= add_base + {32'd0, dns_r};
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          now_r     <= in_ch.now_ns;
          ddraw_r   <= in_ch.delay_draw;
          drop_r    <= 1'b0;
          written_r <= match_w && (last_r != 64'd0);
          dep_r     <= (match_w && (last_r != 64'd0)) ? last_r + 64'(NS_PER_MS) : 64'd0;
        end
      end
      S_PCT: begin
        if (rem_rsp.done && gate) begin
          drop_r <= (cfg.action_mode == MODE_DROP);
          dms_r  <= cfg.min_delay_ms;
        end
      end
      S_DLY: begin
        if (rem_rsp.done) begin
          dms_r <= r16_dms;
        end
      end
      S_MUL: begin
        dns_r <= prod;
      end
      S_ADD: begin
        dep_r     <= add_base + {32'd0, dns_r};
        written_r <= 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_drop_r    <= drop_r;
          out_written_r <= written_r;
          out_dep_r     <= dep_r;
        end
      end
      default: begin
        drop_r <= drop_r;
      end
    endcase
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.drop_packet  = out_drop_r;
  assign out_ch.time_written = out_written_r;
  assign out_ch.departure_ns = out_dep_r;

  a_nomatch_fast: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !match_w |=> state_r == S_DONE)
    else $error("non-matching descriptor did not go straight to verdict");

  a_dep_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_written_r |-> out_dep_r == 64'd0)
    else $error("departure reported without a written time");

  a_last_update: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(last_r) |-> $past(state_r == S_ADD) || $past(accept))
    else $error("last departure changed outside accept or add step");

  a_rem_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) || (state_r == S_DONE) |-> !rem_rsp.busy)
    else $error("remainder unit busy while sequencer is not waiting on it");

endmodule

@@ rtl/core/pdd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// pdd_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module pdd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pdd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [pdd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output pdd_pkg::cfg_t                   cfg
);
  import pdd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_ACTION_MODE:     cfg_nxt.action_mode     = cfg_wdata;
        REG_MATCH_PROTOCOL:  cfg_nxt.match_protocol  = cfg_wdata;
        REG_MATCH_PORT:      cfg_nxt.match_port      = cfg_wdata;
        REG_PERCENT_APPLIED: cfg_nxt.percent_applied = cfg_wdata;
        REG_MIN_DELAY_MS:    cfg_nxt.min_delay_ms    = cfg_wdata;
        REG_MAX_DELAY_MS:    cfg_nxt.max_delay_ms    = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/pdd_rem_unit.sv @@
// ----------------------------------------------------------------------------
// pdd_rem_unit
// Shared serial remainder unit: 32-bit dividend by 16-bit divisor, one
// quotient bit per cycle. A zero divisor leaves the low 16 dividend bits.
// ----------------------------------------------------------------------------
module pdd_rem_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  pdd_pkg::rem_req_t req,
  output pdd_pkg::rem_rsp_t rsp
);
  import pdd_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [31:0]          dvd_r;
  logic [15:0]          div_r;
  logic [15:0]          rem_r;
  logic [16:0]          shifted;
  logic [16:0]          diff;
  logic [15:0]          rem_nxt;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    shifted = {rem_r, dvd_r[31]};
    diff    = shifted - {1'b0, div_r};
    rem_nxt = (shifted >= {1'b0, div_r}) ? diff[15:0] : shifted[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

  // a new start may follow in the cycle that done is shown
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("remainder unit restarted while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("remainder done held longer than one cycle");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && (div_r != 16'd0) |-> rem_r < div_r)
    else $error("remainder not below divisor");

endmodule
